@@ rtl/core/zip_extra_field_parser_defines.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ZIP_EXTRA_FIELD_PARSER_DEFINES_SVH
`define ZIP_EXTRA_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ZEFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zefp same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ZEFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zefp next-cycle check failed");

`endif

@@ rtl/core/zefp_pkg.sv @@
`timescale 1ns / 1ps
package zefp_pkg;

   // Request commands
   typedef enum logic [1:0] {
      CMD_EXTRA  = 2'd0,
      CMD_NAME   = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_type;

   localparam int NUM_FIELDS = 24;

   // Block tags
   localparam logic [15:0] TAG_TIMESTAMP = 16'h5455;
   localparam logic [15:0] TAG_UPATH     = 16'h7075;
   localparam logic [15:0] TAG_UNIX      = 16'h7875;
   localparam logic [15:0] TAG_ZIP64     = 16'h0001;
   localparam logic [15:0] TAG_AES       = 16'h9901;

   // Field indexes
   localparam logic [4:0] F_TS_HAS    = 5'd0;
   localparam logic [4:0] F_TS_FLAGS  = 5'd1;
   localparam logic [4:0] F_TS_MOD    = 5'd2;
   localparam logic [4:0] F_TS_ACC    = 5'd3;
   localparam logic [4:0] F_TS_CRE    = 5'd4;
   localparam logic [4:0] F_UP_HAS    = 5'd5;
   localparam logic [4:0] F_UP_CRC    = 5'd6;
   localparam logic [4:0] F_UP_OFF    = 5'd7;
   localparam logic [4:0] F_UP_LEN    = 5'd8;
   localparam logic [4:0] F_UP_CRC_OK = 5'd9;
   localparam logic [4:0] F_UID       = 5'd10;
   localparam logic [4:0] F_GID       = 5'd11;
   localparam logic [4:0] F_UNIX_HAS  = 5'd12;
   localparam logic [4:0] F_Z64_HAS   = 5'd13;
   localparam logic [4:0] F_Z64_USIZE = 5'd14;
   localparam logic [4:0] F_Z64_CSIZE = 5'd15;
   localparam logic [4:0] F_Z64_ROFF  = 5'd16;
   localparam logic [4:0] F_Z64_DISK  = 5'd17;
   localparam logic [4:0] F_Z64_MASK  = 5'd18;
   localparam logic [4:0] F_AES_HAS   = 5'd19;
   localparam logic [4:0] F_AES_VER   = 5'd20;
   localparam logic [4:0] F_AES_VEND  = 5'd21;
   localparam logic [4:0] F_AES_STR   = 5'd22;
   localparam logic [4:0] F_AES_METH  = 5'd23;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       name_supplied;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  field_id;
      logic [63:0] field_value;
      logic        last_field;
   } rsp_word_type;

   // Completed block handed to the decoder
   typedef struct packed {
      logic [15:0]      tag;
      logic [15:0]      len;
      logic [15:0]      last_off;
      logic [31:0][7:0] raw;
      logic [8:0]       gid_pos;
      logic [7:0]       gid_len;
      logic [31:0]      gid_bytes;
      logic [63:0]      z64_mask;
   } blk_type;

   // Field writes produced by the decoder
   typedef struct packed {
      logic [23:0]       we;
      logic [23:0][63:0] value;
   } fld_wr_type;

   // One reflected CRC-32 byte step
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/zefp_decode.sv @@
`timescale 1ns / 1ps
// Decodes one completed block into field writes.
module zefp_decode (
   input  zefp_pkg::blk_type    blk,
   output zefp_pkg::fld_wr_type wr
);

   logic [16:0] len;
   logic [7:0]  fl;
   logic [16:0] cur_a;
   logic [16:0] cur_c;
   logic        mod_ok;
   logic        acc_ok;
   logic [16:0] us;
   logic [16:0] gp;
   logic [16:0] gs;
   logic [7:0]  mode;

   function automatic logic [63:0] le(input logic [31:0][7:0] r, input logic [4:0] i,
                                      input logic [3:0] n);
      logic [63:0] v;
      logic [4:0]  idx;
      v = 64'd0;
      for (int k = 0; k < 8; k++) begin
         idx = i + 5'(k);
         if (4'(k) < n) begin
            v[8*k +: 8] = r[idx];
         end
      end
      return v;
   endfunction

   always_comb begin
      len    = {1'b0, blk.len};
      wr     = '0;
      fl     = blk.raw[0];
      mode   = blk.raw[4];
      us     = {9'd0, blk.raw[1]};
      gp     = {8'd0, blk.gid_pos};
      gs     = {9'd0, blk.gid_len};
      mod_ok = fl[0] && (len >= 17'd5);
      cur_a  = mod_ok ? 17'd5 : 17'd1;
      acc_ok = fl[1] && (cur_a + 17'd4 <= len);
      cur_c  = acc_ok ? cur_a + 17'd4 : cur_a;
      case (blk.tag)
         zefp_pkg::TAG_TIMESTAMP: begin
            if (len >= 17'd1) begin
               wr.we[zefp_pkg::F_TS_HAS]      = 1'b1;
               wr.value[zefp_pkg::F_TS_HAS]   = 64'd1;
               wr.we[zefp_pkg::F_TS_FLAGS]    = 1'b1;
               wr.value[zefp_pkg::F_TS_FLAGS] = {56'd0, fl};
               wr.we[zefp_pkg::F_TS_MOD]      = mod_ok;
               wr.value[zefp_pkg::F_TS_MOD]   = le(blk.raw, 5'd1, 4'd4);
               wr.we[zefp_pkg::F_TS_ACC]      = acc_ok;
               wr.value[zefp_pkg::F_TS_ACC]   = le(blk.raw, cur_a[4:0], 4'd4);
               wr.we[zefp_pkg::F_TS_CRE]      = fl[2] && (cur_c + 17'd4 <= len);
               wr.value[zefp_pkg::F_TS_CRE]   = le(blk.raw, cur_c[4:0], 4'd4);
            end
         end
         zefp_pkg::TAG_UPATH: begin
            if (len >= 17'd5 && blk.raw[0] == 8'd1) begin
               wr.we[zefp_pkg::F_UP_HAS]    = 1'b1;
               wr.value[zefp_pkg::F_UP_HAS] = 64'd1;
               wr.we[zefp_pkg::F_UP_CRC]    = 1'b1;
               wr.value[zefp_pkg::F_UP_CRC] = le(blk.raw, 5'd1, 4'd4);
               wr.we[zefp_pkg::F_UP_OFF]    = 1'b1;
               wr.value[zefp_pkg::F_UP_OFF] =
                  {47'd0, 17'({1'b0, blk.last_off} + 17'd6 - len)};
               wr.we[zefp_pkg::F_UP_LEN]    = 1'b1;
               wr.value[zefp_pkg::F_UP_LEN] = {47'd0, len - 17'd5};
            end
         end
         zefp_pkg::TAG_UNIX: begin
            if (len >= 17'd4 && blk.raw[0] == 8'd1) begin
               wr.we[zefp_pkg::F_UNIX_HAS]    = 1'b1;
               wr.value[zefp_pkg::F_UNIX_HAS] = 64'd1;
               if (us + 17'd2 <= len) begin
                  wr.we[zefp_pkg::F_UID]    = (us == 17'd2) || (us == 17'd4);
                  wr.value[zefp_pkg::F_UID] = (us == 17'd2) ? le(blk.raw, 5'd2, 4'd2)
                                                            : le(blk.raw, 5'd2, 4'd4);
               end
               if (gp < len && gp + 17'd1 + gs <= len) begin
                  wr.we[zefp_pkg::F_GID]    = (gs == 17'd2) || (gs == 17'd4);
                  wr.value[zefp_pkg::F_GID] = (gs == 17'd2) ? {48'd0, blk.gid_bytes[15:0]}
                                                            : {32'd0, blk.gid_bytes};
               end
            end
         end
         zefp_pkg::TAG_ZIP64: begin
            wr.we[zefp_pkg::F_Z64_HAS]      = 1'b1;
            wr.value[zefp_pkg::F_Z64_HAS]   = 64'd1;
            wr.we[zefp_pkg::F_Z64_USIZE]    = len >= 17'd8;
            wr.value[zefp_pkg::F_Z64_USIZE] = le(blk.raw, 5'd0, 4'd8);
            wr.we[zefp_pkg::F_Z64_CSIZE]    = len >= 17'd16;
            wr.value[zefp_pkg::F_Z64_CSIZE] = le(blk.raw, 5'd8, 4'd8);
            wr.we[zefp_pkg::F_Z64_ROFF]     = len >= 17'd24;
            wr.value[zefp_pkg::F_Z64_ROFF]  = le(blk.raw, 5'd16, 4'd8);
            wr.we[zefp_pkg::F_Z64_DISK]     = len >= 17'd28;
            wr.value[zefp_pkg::F_Z64_DISK]  = le(blk.raw, 5'd24, 4'd4);
            wr.we[zefp_pkg::F_Z64_MASK]     = 1'b1;
            wr.value[zefp_pkg::F_Z64_MASK]  = blk.z64_mask |
               {60'd0, len >= 17'd28, len >= 17'd24, len >= 17'd16, len >= 17'd8};
         end
         zefp_pkg::TAG_AES: begin
            if (len >= 17'd7) begin
               wr.we[zefp_pkg::F_AES_HAS]     = 1'b1;
               wr.value[zefp_pkg::F_AES_HAS]  = 64'd1;
               wr.we[zefp_pkg::F_AES_VER]     = 1'b1;
               wr.value[zefp_pkg::F_AES_VER]  = le(blk.raw, 5'd0, 4'd2);
               wr.we[zefp_pkg::F_AES_VEND]    = 1'b1;
               wr.value[zefp_pkg::F_AES_VEND] = le(blk.raw, 5'd2, 4'd2);
               wr.we[zefp_pkg::F_AES_STR]     = 1'b1;
               wr.value[zefp_pkg::F_AES_STR]  = (mode == 8'd1) ? 64'd128 :
                                                (mode == 8'd2) ? 64'd192 :
                                                (mode == 8'd3) ? 64'd256 : 64'd0;
               wr.we[zefp_pkg::F_AES_METH]    = 1'b1;
               wr.value[zefp_pkg::F_AES_METH] = le(blk.raw, 5'd5, 4'd2);
            end
         end
         default: begin
            wr = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/zip_extra_field_parser.sv @@
`timescale 1ns / 1ps
// Extra-field and filename bytes: one word per cycle, state updated at the accepting edge.
// A completed block is decoded into the fields at the following edge.
// Finish: 24 result words, the first registered after the busy flag is set, then one per cycle
// as taken; requests stall while the field table is read out.
// Synchronous active-high reset clears the parse state (but for the last block offset), fields and the name CRC.
module zip_extra_field_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  zefp_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output zefp_pkg::rsp_word_type rsp_word
);

   // Parse state
   logic [15:0]       area_off_ff,  area_off_in;
   logic              stopped_ff,   stopped_in;
   logic [16:0]       pos_ff,       pos_in;
   logic [23:0]       hdr_ff,       hdr_in;
   logic [15:0]       tag_ff,       tag_in;
   logic [15:0]       len_ff,       len_in;
   logic [31:0][7:0]  raw_ff,       raw_in;
   logic [8:0]        gpos_ff,      gpos_in;
   logic [7:0]        gsize_ff,     gsize_in;
   logic [31:0]       gid_ff,       gid_in;
   logic              cpend_ff,     cpend_in;
   logic [15:0]       coff_ff,      coff_in;
   logic [23:0][63:0] fields_ff,    fields_in;
   logic [31:0]       crc_ff,       crc_in;
   logic              name_end_ff,  name_end_in;
   // Read-out state
   logic              busy_ff,      busy_in;
   logic [4:0]        idx_ff,       idx_in;
   logic              supplied_ff,  supplied_in;
   logic              rsp_valid_ff, rsp_valid_in;
   zefp_pkg::rsp_word_type rsp_ff,  rsp_in;

   zefp_pkg::blk_type    blk;
   zefp_pkg::fld_wr_type wr;

   logic        accept;
   logic [7:0]  b;
   logic [16:0] pos_nx;
   logic [15:0] len_nx;
   logic [16:0] p;
   logic [16:0] gp;
   logic [8:0]  gsum;
   logic [1:0]  gsel;
   logic        load;
   logic [63:0] crc_ok;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign b         = req_word.data_byte;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Block decoder works from registered block state
   always_comb begin
      blk.tag       = tag_ff;
      blk.len       = len_ff;
      blk.last_off  = coff_ff;
      blk.raw       = raw_ff;
      blk.gid_pos   = gpos_ff;
      blk.gid_len   = gsize_ff;
      blk.gid_bytes = gid_ff;
      blk.z64_mask  = fields_ff[zefp_pkg::F_Z64_MASK];
   end

   zefp_decode u_decode (
      .blk (blk),
      .wr  (wr)
   );

   // Next-state logic
   always_comb begin
      area_off_in  = area_off_ff;
      stopped_in   = stopped_ff;
      pos_in       = pos_ff;
      hdr_in       = hdr_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      raw_in       = raw_ff;
      gpos_in      = gpos_ff;
      gsize_in     = gsize_ff;
      gid_in       = gid_ff;
      cpend_in     = 1'b0;
      coff_in      = coff_ff;
      fields_in    = fields_ff;
      crc_in       = crc_ff;
      name_end_in  = name_end_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      supplied_in  = supplied_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pos_nx       = pos_ff + 17'd1;
      len_nx       = len_ff;
      p            = pos_ff - 17'd4;
      gp           = {8'd0, gpos_ff};
      gsum         = 9'(b) + 9'd2;
      // gid byte lane, modulo 4
      gsel         = p[1:0] - gpos_ff[1:0] - 2'd1;
      load         = busy_ff && (!rsp_valid_ff || rsp_ready);
      crc_ok       = 64'd0;

      // Commit the block completed last cycle
      if (cpend_ff) begin
         for (int i = 0; i < zefp_pkg::NUM_FIELDS; i++) begin
            if (wr.we[i]) begin
               fields_in[i] = wr.value[i];
            end
         end
      end

      // Extra-field byte
      if (accept && req_word.command == zefp_pkg::CMD_EXTRA && !stopped_ff) begin
         if (pos_ff < 17'd4) begin
            if (pos_ff == 17'd3) begin
               tag_in   = hdr_ff[15:0];
               len_in   = {b, hdr_ff[23:16]};
               len_nx   = {b, hdr_ff[23:16]};
               hdr_in   = '0;
               raw_in   = '0;
               gpos_in  = '0;
               gsize_in = '0;
               gid_in   = '0;
            end else begin
               hdr_in[8*pos_ff[1:0] +: 8] = b;
            end
         end else begin
            if (p < 17'd32) begin
               raw_in[p[4:0]] = b;
            end
            if (p == 17'd1) begin
               gpos_in  = ({8'd0, gsum} <= {1'b0, len_ff}) ? gsum : 9'd2;
               gsize_in = '0;
            end else if (p >= 17'd2 && p == gp) begin
               gsize_in = b;
            end else if (p >= 17'd2 && p > gp && p <= gp + 17'd4) begin
               gid_in[8*gsel +: 8] = b;
            end
         end
         pos_in = pos_nx;
         if (pos_nx >= 17'd4 && pos_nx == {1'b0, len_nx} + 17'd4) begin
            cpend_in = 1'b1;
            coff_in  = area_off_ff;
            pos_in   = '0;
            hdr_in   = '0;
         end
         if (area_off_ff == 16'hFFFF) begin
            stopped_in = 1'b1;
         end else begin
            area_off_in = area_off_ff + 16'd1;
         end
      end

      // Filename byte
      if (accept && req_word.command == zefp_pkg::CMD_NAME && !name_end_ff) begin
         if (b == 8'd0) begin
            name_end_in = 1'b1;
         end else begin
            crc_in = zefp_pkg::crc_byte(crc_ff, b);
         end
      end

      // Finish starts the read-out
      if (accept && req_word.command == zefp_pkg::CMD_FINISH) begin
         busy_in     = 1'b1;
         idx_in      = '0;
         supplied_in = req_word.name_supplied;
      end

      // Read-out of the field table
      if (fields_ff[zefp_pkg::F_UP_HAS] != 64'd0 &&
          (!supplied_ff || {32'd0, ~crc_ff} == fields_ff[zefp_pkg::F_UP_CRC])) begin
         crc_ok = 64'd1;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.field_id    = idx_ff;
         rsp_in.field_value = (idx_ff == zefp_pkg::F_UP_CRC_OK) ? crc_ok : fields_ff[idx_ff];
         rsp_in.last_field  = (idx_ff == zefp_pkg::F_AES_METH);
         idx_in             = idx_ff + 5'd1;
         if (idx_ff == zefp_pkg::F_AES_METH) begin
            busy_in     = 1'b0;
            area_off_in = '0;
            stopped_in  = 1'b0;
            pos_in      = '0;
            hdr_in      = '0;
            tag_in      = '0;
            len_in      = '0;
            raw_in      = '0;
            gpos_in     = '0;
            gsize_in    = '0;
            gid_in      = '0;
            fields_in   = '0;
            crc_in      = zefp_pkg::CRC_INIT;
            name_end_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_off_ff  <= '0;
         stopped_ff   <= 1'b0;
         pos_ff       <= '0;
         hdr_ff       <= '0;
         tag_ff       <= '0;
         len_ff       <= '0;
         raw_ff       <= '0;
         gpos_ff      <= '0;
         gsize_ff     <= '0;
         gid_ff       <= '0;
         cpend_ff     <= 1'b0;
         fields_ff    <= '0;
         crc_ff       <= zefp_pkg::CRC_INIT;
         name_end_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         area_off_ff  <= area_off_in;
         stopped_ff   <= stopped_in;
         pos_ff       <= pos_in;
         hdr_ff       <= hdr_in;
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         raw_ff       <= raw_in;
         gpos_ff      <= gpos_in;
         gsize_ff     <= gsize_in;
         gid_ff       <= gid_in;
         cpend_ff     <= cpend_in;
         fields_ff    <= fields_in;
         crc_ff       <= crc_in;
         name_end_ff  <= name_end_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      coff_ff     <= coff_in;
      supplied_ff <= supplied_in;
      rsp_ff      <= rsp_in;
   end

endmodule

@@ rtl/core/zefp_checker.sv @@
`timescale 1ns / 1ps
`include "zip_extra_field_parser_defines.svh"
// Port-level checks for the parser.
module zefp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input zefp_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input zefp_pkg::rsp_word_type rsp_word
);

   // Stalled result word holds
   `ZEFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // Only the last field id closes a run
   `ZEFP_ASSERT_SAME(a_last_id, clock, reset, rsp_valid, rsp_word.last_field == (rsp_word.field_id == zefp_pkg::F_AES_METH))

   // Field ids stay within the table
   `ZEFP_ASSERT_SAME(a_id_range, clock, reset, rsp_valid, rsp_word.field_id <= zefp_pkg::F_AES_METH)

   // Requests stall once a finish is taken
   `ZEFP_ASSERT_NEXT(a_finish_stall, clock, reset, req_valid && req_ready && req_word.command == zefp_pkg::CMD_FINISH, !req_ready)

endmodule

bind zip_extra_field_parser zefp_checker u_zefp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

@@ test/zip_extra_field_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of the parser, predicts the field table of every finish
// and compares each result word against the oldest predicted one.
module zip_extra_field_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  zefp_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  zefp_pkg::rsp_word_type rsp_word,
   output int                     error_count,
   output int                     fields_pending,
   output int                     fields_checked
);

   // parser state as seen by the predictor
   logic [15:0] area_pos;
   int          blk_pos;
   logic [15:0] blk_tag;
   logic [15:0] blk_len;
   logic        area_full;
   logic [63:0] hdr_bytes;
   logic [63:0] payload [8];
   logic [63:0] field_tbl [zefp_pkg::NUM_FIELDS];
   logic [31:0] name_crc;
   logic        name_done;

   zefp_pkg::rsp_word_type field_q[$];

   initial begin
      error_count    = 0;
      fields_pending = 0;
      fields_checked = 0;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void clear_parse();
      area_pos  = '0;
      blk_pos   = 0;
      blk_tag   = '0;
      blk_len   = '0;
      area_full = 1'b0;
      hdr_bytes = '0;
      for (int i = 0; i < 8; i++) payload[i] = '0;
      for (int i = 0; i < zefp_pkg::NUM_FIELDS; i++) field_tbl[i] = '0;
      name_crc  = zefp_pkg::CRC_INIT;
      name_done = 1'b0;
   endfunction

   function automatic logic [7:0] pay_byte(input int i);
      return payload[(i >> 3) & 3][(i & 7) * 8 +: 8];
   endfunction

   // little-endian read of n payload bytes, wrapping in the 32-byte window
   function automatic logic [63:0] pay_le(input int i, input int n);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < n; k++) v |= 64'(pay_byte((i + k) & 31)) << (8 * k);
      return v;
   endfunction

   // decode a complete block into the field table
   function automatic void decode_block(input int last_off);
      int         len;
      int         cur;
      int         us;
      int         gpos;
      int         gs;
      logic [7:0] fl;
      logic [7:0] mode;
      len = int'(blk_len);
      case (blk_tag)
         zefp_pkg::TAG_TIMESTAMP: begin
            if (len >= 1) begin
               fl = pay_byte(0);
               field_tbl[zefp_pkg::F_TS_HAS]   = 64'd1;
               field_tbl[zefp_pkg::F_TS_FLAGS] = 64'(fl);
               cur = 1;
               if (fl[0] && cur + 4 <= len) begin
                  field_tbl[zefp_pkg::F_TS_MOD] = pay_le(cur, 4);
                  cur += 4;
               end
               if (fl[1] && cur + 4 <= len) begin
                  field_tbl[zefp_pkg::F_TS_ACC] = pay_le(cur, 4);
                  cur += 4;
               end
               if (fl[2] && cur + 4 <= len) field_tbl[zefp_pkg::F_TS_CRE] = pay_le(cur, 4);
            end
         end
         zefp_pkg::TAG_UPATH: begin
            if (len >= 5 && pay_byte(0) == 8'd1) begin
               field_tbl[zefp_pkg::F_UP_HAS] = 64'd1;
               field_tbl[zefp_pkg::F_UP_CRC] = pay_le(1, 4);
               field_tbl[zefp_pkg::F_UP_OFF] = 64'(last_off + 1 - len + 5);
               field_tbl[zefp_pkg::F_UP_LEN] = 64'(len - 5);
            end
         end
         zefp_pkg::TAG_UNIX: begin
            if (len >= 4 && pay_byte(0) == 8'd1) begin
               us   = int'(pay_byte(1));
               gpos = int'(payload[5][15:0]);
               gs   = int'(payload[5][39:32]);
               if (2 + us <= len) begin
                  if (us == 2) field_tbl[zefp_pkg::F_UID] = pay_le(2, 2);
                  else if (us == 4) field_tbl[zefp_pkg::F_UID] = pay_le(2, 4);
               end
               if (gpos < len && gpos + 1 + gs <= len) begin
                  if (gs == 2) field_tbl[zefp_pkg::F_GID] = {48'd0, payload[4][15:0]};
                  else if (gs == 4) field_tbl[zefp_pkg::F_GID] = {32'd0, payload[4][31:0]};
               end
               field_tbl[zefp_pkg::F_UNIX_HAS] = 64'd1;
            end
         end
         zefp_pkg::TAG_ZIP64: begin
            field_tbl[zefp_pkg::F_Z64_HAS] = 64'd1;
            cur = 0;
            if (cur + 8 <= len) begin
               field_tbl[zefp_pkg::F_Z64_USIZE] = pay_le(cur, 8);
               field_tbl[zefp_pkg::F_Z64_MASK] |= 64'd1;
               cur += 8;
            end
            if (cur + 8 <= len) begin
               field_tbl[zefp_pkg::F_Z64_CSIZE] = pay_le(cur, 8);
               field_tbl[zefp_pkg::F_Z64_MASK] |= 64'd2;
               cur += 8;
            end
            if (cur + 8 <= len) begin
               field_tbl[zefp_pkg::F_Z64_ROFF] = pay_le(cur, 8);
               field_tbl[zefp_pkg::F_Z64_MASK] |= 64'd4;
               cur += 8;
            end
            if (cur + 4 <= len) begin
               field_tbl[zefp_pkg::F_Z64_DISK] = pay_le(cur, 4);
               field_tbl[zefp_pkg::F_Z64_MASK] |= 64'd8;
            end
         end
         zefp_pkg::TAG_AES: begin
            if (len >= 7) begin
               mode = pay_byte(4);
               field_tbl[zefp_pkg::F_AES_HAS]  = 64'd1;
               field_tbl[zefp_pkg::F_AES_VER]  = pay_le(0, 2);
               field_tbl[zefp_pkg::F_AES_VEND] = pay_le(2, 2);
               field_tbl[zefp_pkg::F_AES_STR]  = mode == 8'd1 ? 64'd128 :
                                                 mode == 8'd2 ? 64'd192 :
                                                 mode == 8'd3 ? 64'd256 : 64'd0;
               field_tbl[zefp_pkg::F_AES_METH] = pay_le(5, 2);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void take_extra(input logic [7:0] b);
      int off;
      int p;
      int gpos;
      off = int'(area_pos);
      if (area_full) return;
      if (blk_pos < 4) begin
         hdr_bytes |= 64'(b) << (8 * blk_pos);
         blk_pos++;
         if (blk_pos == 4) begin
            blk_tag   = hdr_bytes[15:0];
            blk_len   = hdr_bytes[31:16];
            hdr_bytes = '0;
            for (int i = 0; i < 8; i++) payload[i] = '0;
         end
      end else begin
         p    = blk_pos - 4;
         gpos = int'(payload[5][15:0]);
         if (p < 32) payload[p >> 3][(p & 7) * 8 +: 8] |= b;
         // uid size picks where the gid size byte sits
         if (p == 1)
            payload[5] = (2 + int'(b) <= int'(blk_len)) ? 64'(2 + int'(b)) : 64'd2;
         else if (p >= 2 && p == gpos)
            payload[5] |= 64'(b) << 32;
         else if (p >= 2 && p > gpos && p <= gpos + 4)
            payload[4] |= 64'(b) << (8 * (p - gpos - 1));
         blk_pos++;
      end
      if (blk_pos >= 4 && blk_pos == 4 + int'(blk_len)) begin
         decode_block(off);
         blk_pos   = 0;
         hdr_bytes = '0;
      end
      if (area_pos == 16'hFFFF) area_full = 1'b1;
      else area_pos++;
   endfunction

   function automatic void take_name(input logic [7:0] b);
      logic [31:0] c;
      if (name_done) return;
      if (b == 8'd0) begin
         name_done = 1'b1;
         return;
      end
      c = name_crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ zefp_pkg::CRC_POLY) : (c >> 1);
      name_crc = c;
   endfunction

   function automatic void take_finish(input logic have_name);
      zefp_pkg::rsp_word_type w;
      if (field_tbl[zefp_pkg::F_UP_HAS] != 0)
         field_tbl[zefp_pkg::F_UP_CRC_OK] =
            (!have_name || {32'd0, ~name_crc} == field_tbl[zefp_pkg::F_UP_CRC])
            ? 64'd1 : 64'd0;
      else
         field_tbl[zefp_pkg::F_UP_CRC_OK] = 64'd0;
      for (int k = 0; k < zefp_pkg::NUM_FIELDS; k++) begin
         w.field_id    = 5'(k);
         w.field_value = field_tbl[k];
         w.last_field  = (k == zefp_pkg::NUM_FIELDS - 1);
         field_q.push_back(w);
      end
      clear_parse();
   endfunction

   // compare taken results, then fold in the accepted request
   always @(posedge clock) begin
      zefp_pkg::rsp_word_type want;
      if (reset) begin
         clear_parse();
         field_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            fields_checked++;
            if (field_q.size() == 0) begin
               report("unexpected result word, field_id", 64'(rsp_word.field_id), 64'd0);
            end else begin
               want = field_q.pop_front();
               if (rsp_word.field_id !== want.field_id)
                  report("field_id", 64'(rsp_word.field_id), 64'(want.field_id));
               if (rsp_word.field_value !== want.field_value)
                  report($sformatf("field_value of id %0d", want.field_id),
                         rsp_word.field_value, want.field_value);
               if (rsp_word.last_field !== want.last_field)
                  report("last_field", 64'(rsp_word.last_field), 64'(want.last_field));
            end
         end
         if (req_valid && req_ready) begin
            case (req_word.command)
               zefp_pkg::CMD_EXTRA:  take_extra(req_word.data_byte);
               zefp_pkg::CMD_NAME:   take_name(req_word.data_byte);
               zefp_pkg::CMD_FINISH: take_finish(req_word.name_supplied);
               default: ;
            endcase
         end
      end
      fields_pending = field_q.size();
   end

endmodule

@@ test/tb_zip_extra_field_parser.sv @@
`timescale 1ns / 1ps
// Stimulus for the extra-field parser: directed blocks, then random parse
// sessions of well-formed blocks with noise mixed in.
module tb_zip_extra_field_parser;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   zefp_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   zefp_pkg::rsp_word_type rsp_word;

   int error_count;
   int fields_pending;
   int fields_checked;
   int words_sent;
   int sessions;
   int stall_left;
   bit calm;

   zip_extra_field_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   zip_extra_field_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .error_count    (error_count),
      .fields_pending (fields_pending),
      .fields_checked (fields_checked)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog
   initial begin
      #8_000_000;
      $display("zip_extra_field_parser test failed");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // result-side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = gap_len();
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // one request word; called and returns at a falling edge
   task automatic send(input logic [1:0] cmd, input logic [7:0] b, input logic have_name);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= '{command: cmd, data_byte: b, name_supplied: have_name};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (fields_pending != 0) @(negedge clock);
   endtask

   // header and payload, optionally cut short
   task automatic put_block(input logic [15:0] tag, input logic [7:0] pl[$], input bit cut);
      logic [7:0] s[$];
      int         n;
      s = {tag[7:0], tag[15:8], 8'(pl.size()), 8'(pl.size() >> 8)};
      foreach (pl[i]) s.push_back(pl[i]);
      n = cut ? $urandom_range(0, s.size() - 1) : s.size();
      for (int i = 0; i < n; i++) send(zefp_pkg::CMD_EXTRA, s[i], 1'b0);
   endtask

   task automatic send_name(input logic [7:0] nm[$]);
      foreach (nm[i]) send(zefp_pkg::CMD_NAME, nm[i], 1'b0);
      // zero byte ends the name; trailing bytes must not count
      if ($urandom_range(0, 5) == 0) begin
         send(zefp_pkg::CMD_NAME, 8'd0, 1'b0);
         repeat ($urandom_range(1, 3)) send(zefp_pkg::CMD_NAME, 8'($urandom), 1'b0);
      end
   endtask

   function automatic int id_size();
      case ($urandom_range(0, 4))
         0, 1:    return 2;
         2, 3:    return 4;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   // payload with random content, shaped to the tag
   function automatic void make_payload(input logic [15:0] tag, input logic [31:0] crc,
                                        ref logic [7:0] pl[$]);
      logic [7:0] fl;
      int         n;
      pl.delete();
      case (tag)
         zefp_pkg::TAG_TIMESTAMP: begin
            fl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            pl.push_back(fl);
            n = 4 * $countones(fl[2:0]);
            if ($urandom_range(0, 4) == 0) n = n - $urandom_range(0, 4);
            if (n < 0) n = 0;
            repeat (n) pl.push_back(8'($urandom));
         end
         zefp_pkg::TAG_UPATH: begin
            pl.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd1);
            if ($urandom_range(0, 4) == 0) crc = $urandom;
            for (int i = 0; i < 4; i++) pl.push_back(crc[8 * i +: 8]);
            repeat ($urandom_range(0, 6)) pl.push_back(8'($urandom_range(32, 126)));
         end
         zefp_pkg::TAG_UNIX: begin
            pl.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 3)) : 8'd1);
            n = id_size();
            pl.push_back(8'(n));
            repeat (n) pl.push_back(8'($urandom));
            n = id_size();
            pl.push_back(8'(n));
            repeat (n) pl.push_back(8'($urandom));
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) void'(pl.pop_back());
         end
         zefp_pkg::TAG_ZIP64: begin
            case ($urandom_range(0, 6))
               0: n = 0;
               1: n = 8;
               2: n = 16;
               3: n = 24;
               4: n = 28;
               5: n = 4;
               default: n = $urandom_range(0, 40);
            endcase
            repeat (n) pl.push_back(8'($urandom));
         end
         zefp_pkg::TAG_AES: begin
            repeat (4) pl.push_back(8'($urandom));
            pl.push_back(8'($urandom_range(0, 4)));
            repeat (2) pl.push_back(8'($urandom));
            if ($urandom_range(0, 5) == 0) void'(pl.pop_back());
            else if ($urandom_range(0, 5) == 0) pl.push_back(8'($urandom));
         end
         default: repeat ($urandom_range(0, 10)) pl.push_back(8'($urandom));
      endcase
   endfunction

   function automatic logic [15:0] pick_tag();
      case ($urandom_range(0, 5))
         0:       return zefp_pkg::TAG_TIMESTAMP;
         1:       return zefp_pkg::TAG_UPATH;
         2:       return zefp_pkg::TAG_UNIX;
         3:       return zefp_pkg::TAG_ZIP64;
         4:       return zefp_pkg::TAG_AES;
         default: return 16'($urandom);
      endcase
   endfunction

   // one filename and up to four blocks, in either order, then finish
   task automatic run_session(input bit drain);
      logic [7:0]  nm[$];
      logic [7:0]  pl[$];
      logic [31:0] crc;
      logic [15:0] tag;
      int          nb;
      bit          name_first;
      repeat ($urandom_range(0, 8)) nm.push_back(8'($urandom_range(1, 255)));
      crc = zefp_pkg::CRC_INIT;
      foreach (nm[i]) crc = zefp_pkg::crc_byte(crc, nm[i]);
      crc = ~crc;
      name_first = 1'($urandom_range(0, 1));
      if (name_first) send_name(nm);
      nb = $urandom_range(0, 4);
      for (int i = 0; i < nb; i++) begin
         tag = pick_tag();
         make_payload(tag, crc, pl);
         put_block(tag, pl, i == nb - 1 && $urandom_range(0, 4) == 0);
      end
      if (!name_first) send_name(nm);
      if ($urandom_range(0, 7) == 0) send(CMD_UNUSED, 8'($urandom), 1'($urandom));
      send(zefp_pkg::CMD_FINISH, 8'($urandom), $urandom_range(0, 5) != 0);
      sessions++;
      if (drain) wait_drained();
   endtask

   initial begin
      logic [7:0]  pl[$];
      logic [31:0] crc;
      int          base;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      rsp_ready  = 1'b0;
      stall_left = 0;
      calm       = 1'b0;
      words_sent = 0;
      sessions   = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero-length unknown block, then AES at 256 bits, finish without a name
      put_block(16'hFFFF, pl, 1'b0);
      pl = {8'h02, 8'h00, 8'h41, 8'h45, 8'h03, 8'h08, 8'h00};
      put_block(zefp_pkg::TAG_AES, pl, 1'b0);
      send(zefp_pkg::CMD_FINISH, 8'hFF, 1'b0);
      // unicode path whose CRC matches "ab", name cut by a zero byte, unused command
      crc = ~zefp_pkg::crc_byte(zefp_pkg::crc_byte(zefp_pkg::CRC_INIT, 8'h61), 8'h62);
      pl = {8'h01, crc[7:0], crc[15:8], crc[23:16], crc[31:24], 8'h78};
      put_block(zefp_pkg::TAG_UPATH, pl, 1'b0);
      send(zefp_pkg::CMD_NAME, 8'h61, 1'b0);
      send(zefp_pkg::CMD_NAME, 8'h62, 1'b0);
      send(zefp_pkg::CMD_NAME, 8'h00, 1'b0);
      send(zefp_pkg::CMD_NAME, 8'h63, 1'b0);
      send(CMD_UNUSED, 8'h00, 1'b1);
      send(zefp_pkg::CMD_FINISH, 8'h00, 1'b1);
      // finish on an empty state
      send(zefp_pkg::CMD_FINISH, 8'h00, 1'b1);
      wait_drained();

      // random sessions; some run without idling, some drain before the next
      base = words_sent;
      while (words_sent - base < 100) begin
         calm = ($urandom_range(0, 3) == 0);
         run_session($urandom_range(0, 2) == 0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      @(negedge clock);

      while (fields_pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("Sent %0d request words over %0d random sessions plus directed blocks;",
               words_sent, sessions);
      $display("%0d result words compared under random stalls.", fields_checked);
      if (error_count == 0 && fields_pending == 0)
         $display("zip_extra_field_parser test passed");
      else
         $display("zip_extra_field_parser test failed");
      $finish;
   end

endmodule

@@ zip_extra_field_parser.f @@
+incdir+rtl/core
rtl/core/zefp_pkg.sv
rtl/core/zefp_decode.sv
rtl/core/zip_extra_field_parser.sv
rtl/core/zefp_checker.sv
test/zip_extra_field_checker.sv
test/tb_zip_extra_field_parser.sv
